// ===== rtl/wdl_pkg.sv =====
// wdl_pkg: shared types, codes and constants of the word dictionary lookup core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package wdl_pkg;

  localparam int unsigned ENTRIES_DEF     = 64;
  localparam int unsigned NAME_CHARS_DEF  = 15;
  localparam int unsigned ACTION_BITS_DEF = 32;

  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7a;
  localparam logic [7:0] CASE_DIFF = 8'd32;

  typedef enum logic [1:0] {
    OP_DEFINE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_MARK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_IMMEDIATE = 2'd1,
    KIND_NORMAL    = 2'd2,
    KIND_RSVD      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_LONG = 2'd1,
    ST_FULL     = 2'd2,
    ST_NO_ENTRY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT
  } state_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  word_len;
    logic [7:0]  ch;
    logic [31:0] action;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] found_action;
    logic [5:0]  found_index;
    logic [1:0]  status;
    logic [31:0] latest_action;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= LOWER_A && c <= LOWER_Z) r = c - CASE_DIFF;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wdl_cell.sv =====
// wdl_cell: one dictionary entry holding a folded name, length, action and mark
// depends on wdl_pkg; compares one streamed character per cycle while cmp_en_i is high
`timescale 1ns / 1ps
`default_nettype none
module wdl_cell #(
  parameter int unsigned NAME_CHARS  = wdl_pkg::NAME_CHARS_DEF,
  parameter int unsigned ACTION_BITS = wdl_pkg::ACTION_BITS_DEF,
  parameter int unsigned CW          = $clog2(NAME_CHARS + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   write_i,
  input  wire logic                   mark_i,
  input  wire logic [7:0]             len_i,
  input  wire logic [ACTION_BITS-1:0] action_i,
  input  wire logic [NAME_CHARS*8-1:0] wname_i,
  input  wire logic                   restart_i,
  input  wire logic                   cmp_en_i,
  input  wire logic [CW-1:0]          pos_i,
  input  wire logic [7:0]             ch_i,
  output logic                        match_o,
  output logic                        imm_o,
  output logic [ACTION_BITS-1:0]      action_o
);
  import wdl_pkg::*;

  logic [NAME_CHARS*8-1:0] name_q;
  logic [7:0]              len_q;
  logic [ACTION_BITS-1:0]  action_q;
  logic                    imm_q;
  logic                    cand_q, cand_d;

  always_ff @(posedge clk_i) begin
    if (write_i) begin
      name_q   <= wname_i;
      len_q    <= len_i;
      action_q <= action_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imm_q  <= 1'b0;
      cand_q <= 1'b1;
    end else begin
      if (write_i) imm_q <= 1'b0;
      else if (mark_i) imm_q <= 1'b1;
      cand_q <= cand_d;
    end
  end

  always_comb begin
    cand_d = cand_q;
    if (restart_i) cand_d = (len_q == len_i);
    if (cmp_en_i && (restart_i || cand_q)) begin
      cand_d = (restart_i ? (len_q == len_i) : 1'b1) &&
               (name_q[pos_i*8 +: 8] == fold(ch_i));
    end
  end

  assign match_o  = cand_q;
  assign imm_o    = imm_q;
  assign action_o = action_q;
endmodule
`default_nettype wire

// ===== rtl/word_dictionary_lookup_core.sv =====
// word_dictionary_lookup_core: dictionary of named entries, one cell per entry
// depends on wdl_pkg and wdl_cell
// a final character or a mark moves the FSM to S_SCAN, which registers the result and strobe
// throughput: one transaction per cycle while characters stream; busy stays high through
// S_SCAN and S_REPORT after a name end or a mark; the receiver cannot stall results
// reset clears the entry count, marks and name progress; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module word_dictionary_lookup_core #(
  parameter int unsigned ENTRIES     = wdl_pkg::ENTRIES_DEF,
  parameter int unsigned NAME_CHARS  = wdl_pkg::NAME_CHARS_DEF,
  parameter int unsigned ACTION_BITS = wdl_pkg::ACTION_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire wdl_pkg::item_t  item_i,
  output logic                 strobe,
  output wdl_pkg::result_t     result_o
);
  import wdl_pkg::*;

  localparam int unsigned EW = $clog2(ENTRIES);
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam int unsigned CW = $clog2(NAME_CHARS + 1);

  state_e state_q, state_d;
  logic [NW-1:0] count_q;
  logic [7:0]    rcv_q, rcv_d;
  logic [1:0]    cop_q;
  logic [7:0]    clen_q;
  logic [NAME_CHARS*8-1:0] pend_q, pend_d;

  logic accept, is_name, restart, final_ch, do_write, do_mark;
  logic [7:0] base;
  logic [ACTION_BITS-1:0] act_in;

  logic [ENTRIES-1:0] match, imm, wr, mk;
  logic [ACTION_BITS-1:0] acts [ENTRIES];

  // pending result fields
  logic [1:0] op_q;
  logic [7:0] len_q;
  logic [1:0] st_q;
  logic [5:0] idx_q;
  result_t res_q;
  logic strobe_q;

  assign accept  = start && !busy;
  assign busy    = (state_q != S_IDLE);
  assign is_name = (item_i.op == OP_DEFINE) || (item_i.op == OP_LOOKUP);
  assign restart = accept && is_name &&
                   ((rcv_q == 8'd0) || item_i.op != cop_q || item_i.word_len != clen_q);
  assign base    = restart ? 8'd0 : rcv_q;
  assign final_ch = accept && is_name &&
                    ((item_i.word_len == 8'd0) || (base + 8'd1 >= item_i.word_len));
  assign act_in  = ACTION_BITS'(item_i.action);

  always_comb begin
    pend_d = pend_q;
    if (accept && is_name && item_i.word_len != 8'd0 && base < 8'(NAME_CHARS))
      pend_d[base[CW-1:0]*8 +: 8] = fold(item_i.ch);
  end

  always_comb begin
    rcv_d = rcv_q;
    if (accept && is_name) rcv_d = final_ch ? 8'd0 : base + 8'd1;
  end

  assign do_write = final_ch && item_i.op == OP_DEFINE &&
                    item_i.word_len <= 8'(NAME_CHARS) && count_q < NW'(ENTRIES);
  assign do_mark  = accept && item_i.op == OP_MARK && count_q != '0;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      assign wr[g] = do_write && count_q == NW'(g);
      assign mk[g] = do_mark && count_q == NW'(g + 1);
      wdl_cell #(.NAME_CHARS(NAME_CHARS), .ACTION_BITS(ACTION_BITS), .CW(CW)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .write_i   (wr[g]),
        .mark_i    (mk[g]),
        .len_i     (item_i.word_len),
        .action_i  (act_in),
        .wname_i   (pend_d),
        .restart_i (restart),
        .cmp_en_i  (accept && is_name && item_i.word_len != 8'd0 &&
                    base < 8'(NAME_CHARS)),
        .pos_i     (base[CW-1:0]),
        .ch_i      (item_i.ch),
        .match_o   (match[g]),
        .imm_o     (imm[g]),
        .action_o  (acts[g])
      );
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rcv_q    <= '0;
      cop_q    <= '0;
      clen_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rcv_q    <= rcv_d;
      strobe_q <= (state_q == S_SCAN);
      if (do_write) count_q <= count_q + 1'b1;
      if (accept && is_name) begin
        cop_q  <= item_i.op;
        clen_q <= item_i.word_len;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (accept && (final_ch || item_i.op == OP_MARK)) begin
      op_q  <= item_i.op;
      len_q <= item_i.word_len;
      st_q  <= ST_OK;
      idx_q <= '0;
      if (item_i.op == OP_MARK) begin
        if (count_q == '0) st_q <= ST_NO_ENTRY;
        else idx_q <= 6'(count_q - 1'b1);
      end else if (item_i.op == OP_DEFINE) begin
        if (item_i.word_len > 8'(NAME_CHARS)) st_q <= ST_TOO_LONG;
        else if (count_q >= NW'(ENTRIES)) st_q <= ST_FULL;
        else idx_q <= 6'(count_q);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept && (final_ch || item_i.op == OP_MARK)) state_d = S_SCAN;
      S_SCAN:   state_d = S_REPORT;
      S_REPORT: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // newest-first priority over the row of cells
  logic hit;
  logic [EW-1:0] hit_idx;
  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i] && NW'(i) < count_q) begin
        hit = 1'b1;
        hit_idx = EW'(i);
      end
    end
  end

  logic [ACTION_BITS-1:0] latest;
  assign latest = (count_q == '0) ? '0 : acts[EW'(count_q - 1'b1)];

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) begin
      res_q.kind          <= KIND_NONE;
      res_q.found_action  <= '0;
      res_q.found_index   <= idx_q;
      res_q.status        <= st_q;
      res_q.latest_action <= 32'(latest);
      if (op_q == OP_LOOKUP && len_q <= 8'(NAME_CHARS) && hit) begin
        res_q.kind         <= imm[hit_idx] ? KIND_IMMEDIATE : KIND_NORMAL;
        res_q.found_action <= 32'(acts[hit_idx]);
        res_q.found_index  <= 6'(hit_idx);
      end
    end
  end

  assign strobe   = strobe_q;
  assign result_o = res_q;

  a_strobe_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(state_q) == S_SCAN) else $error("strobe without scan");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= NW'(ENTRIES)) else $error("entry count overflow");
  a_busy_on_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe |-> $past(busy)) else $error("result while idle");
endmodule
`default_nettype wire
